### src/itoa_pkg.sv
// Shared types, constants and helpers of the integer to ASCII formatter.
`default_nettype none

package itoa_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned WIDTH_W = 7;
  localparam int unsigned FLAGS_W = 3;
  localparam int unsigned CHAR_W  = 8;

  // A 64-bit value has at most 20 decimal digits; hex uses the low 16 of them.
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned DIGITS_W   = 4 * NUM_DIGITS;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned STEP_W     = 6;

  localparam int unsigned FLAG_TWOS = 0;
  localparam int unsigned FLAG_ZERO = 1;
  localparam int unsigned FLAG_ALT  = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  localparam logic [CHAR_W-1:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // Formatting options that the sequencer keeps for one number.
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic               zero;
    logic               alt;
    logic               neg;
  } itoa_req_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] digit);
    return HEX_CHARS[digit];
  endfunction

endpackage

`default_nettype wire

### src/itoa_if.sv
// Valid/ready channel interfaces for numbers in and characters out.
`default_nettype none

interface itoa_in_if;
  import itoa_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               base_is_hex;
  logic [WIDTH_W-1:0] pad_width;
  logic [FLAGS_W-1:0] format_flags;

  modport source (output valid, value, base_is_hex, pad_width, format_flags, input ready);
  modport sink   (input valid, value, base_is_hex, pad_width, format_flags, output ready);
endinterface

interface itoa_out_if;
  import itoa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

### src/itoa_conv.sv
// Binary to digit converter: shift-and-add-3 unit, one binary bit per cycle.
`default_nettype none

module itoa_conv (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         hex_i,
  input  wire logic [itoa_pkg::VALUE_W-1:0] value_i,
  output logic                              done_o,
  output logic [itoa_pkg::DIGITS_W-1:0]     digits_o
);
  import itoa_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [VALUE_W-1:0]  bin_q, bin_d;
  logic [DIGITS_W-1:0] bcd_q, bcd_d;
  logic [DIGITS_W-1:0] bcd_adj;

  // Every BCD digit of 5 or more is corrected by 3 before the doubling shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      step_d = '0;
      bin_d  = value_i;
      if (hex_i) begin
        // Hex digits are the nibbles themselves.
        bcd_d  = {{(DIGITS_W-VALUE_W){1'b0}}, value_i};
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        bcd_d  = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      bcd_d  = {bcd_adj[DIGITS_W-2:0], bin_q[VALUE_W-1]};
      bin_d  = {bin_q[VALUE_W-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (step_q == {STEP_W{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

`default_nettype wire

### src/itoa_emit.sv
// Character sequencer: trims leading zeros, then emits padding/prefix, sign and digits.
`default_nettype none

module itoa_emit #(
  parameter int unsigned MAX_FIELD_WIDTH = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire itoa_pkg::itoa_req_t         req_i,
  input  wire logic                        conv_done_i,
  input  wire logic [itoa_pkg::DIGITS_W-1:0] conv_digits_i,
  output logic                             idle_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [itoa_pkg::CHAR_W-1:0]      out_char_o,
  output logic                             out_last_o
);
  import itoa_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CONV = 3'd1;
  localparam logic [2:0] PH_NORM = 3'd2;
  localparam logic [2:0] PH_PAD  = 3'd3;
  localparam logic [2:0] PH_PRE0 = 3'd4;
  localparam logic [2:0] PH_PRE1 = 3'd5;
  localparam logic [2:0] PH_SIGN = 3'd6;
  localparam logic [2:0] PH_DIG  = 3'd7;

  localparam logic [WIDTH_W-1:0] MaxWidth = WIDTH_W'(MAX_FIELD_WIDTH);

  logic [2:0]          phase_q, phase_d;
  itoa_req_t           req_q, req_d;
  logic [DIGITS_W-1:0] digits_q, digits_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [WIDTH_W-1:0]  pad_q, pad_d;
  logic                out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic                out_last_q, out_last_d;

  logic                slot;
  logic [3:0]          top_digit;
  logic [WIDTH_W-1:0]  width_eff, total, pad_calc;
  logic [2:0]          sign_or_dig, first_phase, after_pad, after_pre1;

  assign slot      = !out_valid_q || out_ready_i;
  assign top_digit = digits_q[DIGITS_W-1 -: 4];
  assign width_eff = (req_q.width > MaxWidth) ? MaxWidth : req_q.width;
  assign total     = WIDTH_W'(cnt_q) + WIDTH_W'(req_q.neg) + (req_q.alt ? WIDTH_W'(2) : '0);
  assign pad_calc  = (total < width_eff) ? (width_eff - total) : '0;

  // Zero pad puts the prefix ahead of the zeros; space pad puts it after the spaces.
  assign sign_or_dig = req_q.neg ? PH_SIGN : PH_DIG;
  assign after_pad   = (!req_q.zero && req_q.alt) ? PH_PRE0 : sign_or_dig;
  assign after_pre1  = (req_q.zero && (pad_q != '0)) ? PH_PAD : sign_or_dig;
  always_comb begin
    if (req_q.zero) begin
      first_phase = req_q.alt ? PH_PRE0 : ((pad_calc != '0) ? PH_PAD : sign_or_dig);
    end else begin
      first_phase = (pad_calc != '0) ? PH_PAD : (req_q.alt ? PH_PRE0 : sign_or_dig);
    end
  end

  always_comb begin
    phase_d     = phase_q;
    req_d       = req_q;
    digits_d    = digits_q;
    cnt_d       = cnt_q;
    pad_d       = pad_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          phase_d = PH_CONV;
        end
      end
      PH_CONV: begin
        if (conv_done_i) begin
          digits_d = conv_digits_i;
          cnt_d    = COUNT_W'(NUM_DIGITS);
          phase_d  = PH_NORM;
        end
      end
      PH_NORM: begin
        if ((cnt_q > COUNT_W'(1)) && (top_digit == 4'd0)) begin
          digits_d = {digits_q[DIGITS_W-5:0], 4'd0};
          cnt_d    = cnt_q - COUNT_W'(1);
        end else begin
          pad_d   = pad_calc;
          phase_d = first_phase;
        end
      end
      PH_PAD: begin
        if (slot) begin
          out_valid_d = 1'b1;
          out_char_d  = req_q.zero ? CHAR_ZERO : CHAR_SPACE;
          out_last_d  = 1'b0;
          pad_d       = pad_q - WIDTH_W'(1);
          if (pad_q == WIDTH_W'(1)) begin
            phase_d = after_pad;
          end
        end
      end
      PH_PRE0: begin
        if (slot) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_ZERO;
          out_last_d  = 1'b0;
          phase_d     = PH_PRE1;
        end
      end
      PH_PRE1: begin
        if (slot) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_X;
          out_last_d  = 1'b0;
          phase_d     = after_pre1;
        end
      end
      PH_SIGN: begin
        if (slot) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          phase_d     = PH_DIG;
        end
      end
      PH_DIG: begin
        if (slot) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(top_digit);
          out_last_d  = (cnt_q == COUNT_W'(1));
          digits_d    = {digits_q[DIGITS_W-5:0], 4'd0};
          cnt_d       = cnt_q - COUNT_W'(1);
          if (cnt_q == COUNT_W'(1)) begin
            phase_d = PH_IDLE;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      pad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      pad_q       <= pad_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    digits_q   <= digits_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign idle_o      = (phase_q == PH_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  a_dig_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DIG || phase_q == PH_NORM) |-> cnt_q != '0)
    else $error("digit phase entered with no digits left");

  a_pad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAD |-> pad_q != '0)
    else $error("pad phase entered with no padding left");

  a_conv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done_i |-> phase_q == PH_CONV)
    else $error("converter finished while the sequencer was not waiting");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DIG && slot && cnt_q == COUNT_W'(1)) |=> (out_last_q && phase_q == PH_IDLE))
    else $error("final digit did not end the number");

endmodule

`default_nettype wire

### src/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter.
//
// One number enters on in_i (value, base_is_hex, pad_width, format_flags) and
// leaves on out_o as ASCII characters, one per transaction, with last_char set
// on the final one. in_i.ready is high only while no number is in work.
// A decimal number passes through the shift-and-add-3 converter, one binary
// bit per cycle; a hex number is loaded there as its nibbles. Leading zero
// digits are then trimmed at one digit per cycle, down to a single digit, and
// the characters leave at one per cycle from an output register while out_o
// is not stalled.
// When out_o stalls, the output register holds its character and the
// sequencer waits; nothing is lost. The next number is accepted as soon as the
// last character is in the output register, even if it is not taken yet.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
`default_nettype none

module integer_to_ascii_formatter_unit #(
  parameter int unsigned MAX_FIELD_WIDTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  itoa_in_if.sink   in_i,
  itoa_out_if.source out_o
);
  import itoa_pkg::*;

  logic                start;
  logic                idle;
  logic                neg;
  logic [VALUE_W-1:0]  magnitude;
  itoa_req_t           req;
  logic                conv_done;
  logic [DIGITS_W-1:0] conv_digits;

  assign in_i.ready = idle;
  assign start      = in_i.valid && idle;

  assign neg       = in_i.format_flags[FLAG_TWOS] && in_i.value[VALUE_W-1];
  assign magnitude = neg ? (VALUE_W'(0) - in_i.value) : in_i.value;

  assign req.width = in_i.pad_width;
  assign req.zero  = in_i.format_flags[FLAG_ZERO];
  assign req.alt   = in_i.format_flags[FLAG_ALT];
  assign req.neg   = neg;

  itoa_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .hex_i    (in_i.base_is_hex),
    .value_i  (magnitude),
    .done_o   (conv_done),
    .digits_o (conv_digits)
  );

  itoa_emit #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_i         (req),
    .conv_done_i   (conv_done),
    .conv_digits_i (conv_digits),
    .idle_o        (idle),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_char_o    (out_o.out_char),
    .out_last_o    (out_o.last_char)
  );

endmodule

`default_nettype wire
